### sv/sma_pkg.sv
`timescale 1ns / 1ps

package sma_pkg;

	localparam int DATA_W  = 32;
	localparam int ACT_W   = 4;
	localparam int INDEX_W = 3;
	localparam int ITER_W  = 5;
	localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(DATA_W - 1);

	// operation codes carried by an input item
	typedef enum logic [ACT_W-1:0] {
		ACT_NOP    = 4'd0,
		ACT_PUSH   = 4'd1,
		ACT_DUP    = 4'd2,
		ACT_DROP   = 4'd3,
		ACT_OVER   = 4'd4,
		ACT_AND    = 4'd5,
		ACT_OR     = 4'd6,
		ACT_XOR    = 4'd7,
		ACT_INVERT = 4'd8,
		ACT_ADD    = 4'd9,
		ACT_SUB    = 4'd10,
		ACT_MUL    = 4'd11,
		ACT_DIV    = 4'd12,
		ACT_MOD    = 4'd13
	} action_t;

	// operations of the shared arithmetic unit
	typedef enum logic [2:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV,
		OP_MOD
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	typedef struct packed {
		logic done;
		logic div_err;
	} alu_rsp_t;

	// top level sequencer
	typedef enum logic [2:0] {
		S_IDLE,
		S_RD_TOP,
		S_RD_BELOW,
		S_CAP,
		S_START,
		S_EXEC,
		S_FINISH
	} seq_state_t;

	// arithmetic unit sequencer
	typedef enum logic [2:0] {
		U_IDLE,
		U_ARITH,
		U_ABS_N,
		U_ABS_D,
		U_LOOP,
		U_FIX,
		U_DONE
	} alu_state_t;

endpackage

### sv/sma_cmd_if.sv
`timescale 1ns / 1ps

interface sma_cmd_if;
	import sma_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [ACT_W-1:0]         action;
	logic signed [DATA_W-1:0] literal;

	modport source (output valid, output action, output literal, input ready);
	modport sink   (input valid, input action, input literal, output ready);
endinterface

### sv/sma_rsp_if.sv
`timescale 1ns / 1ps

interface sma_rsp_if;
	import sma_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] top_value;
	logic signed [DATA_W-1:0] popped_value;
	logic                     divide_error;
	logic [INDEX_W-1:0]       stack_index;

	modport source (output valid, output top_value, output popped_value,
		output divide_error, output stack_index, input ready);
	modport sink   (input valid, input top_value, input popped_value,
		input divide_error, input stack_index, output ready);
endinterface

### sv/stack_machine_alu.sv
`timescale 1ns / 1ps

// Forth-style data stack with an arithmetic unit.
// cmd channel: one item per operation (action code, literal for push).
// rsp channel: one item per command: top of stack, popped operand,
// divide error flag and the low three bits of the stack pointer.
// The stack is a circular RAM of STACK_DEPTH words; the pointer wraps, so
// it never overflows or underflows. Per-entry valid flops make entries that
// were never written read as zero.
// Work per item: stack and logic operations take two reads through the single
// RAM read port, capture and finish; add and sub, mul (32 shift-add steps),
// div and mod (absolute values, 32 restoring steps, sign fix) also run the
// arithmetic unit, which goes straight to done on a zero divisor.
// One item is in work at a time; cmd.ready is high only while idle, so the
// next item is taken only after the current one has finished.
// Results sit in an output register: a new item is accepted while a result
// waits, and a finished item waits in place until that register frees.
// Reset clears the pointer, all entry valid flags and the output valid flag; the
// block is ready in the first cycle after reset.
module stack_machine_alu #(
	parameter int STACK_DEPTH = 8
) (
	input logic clk,
	input logic arst_n,
	sma_cmd_if.sink   cmd,
	sma_rsp_if.source rsp
);
	import sma_pkg::*;

	localparam int PTR_W = $clog2(STACK_DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(STACK_DEPTH - 1);

	seq_state_t        state_q, state_d;
	logic [ACT_W-1:0]  action_q;
	logic [DATA_W-1:0] literal_q;
	logic [PTR_W-1:0]  sp_q, sp_next, sp_prev;
	logic [DATA_W-1:0] top_q, below_q;
	logic [STACK_DEPTH-1:0] valid_q;
	logic              rdv_q;

	logic              out_valid_q;
	logic [DATA_W-1:0] out_top_q, out_pop_q;
	logic              out_err_q;
	logic [INDEX_W-1:0] out_idx_q;

	logic              ram_re, ram_we;
	logic [PTR_W-1:0]  ram_raddr, ram_waddr;
	logic [DATA_W-1:0] ram_wdata, ram_rdata, rd_word;

	alu_req_t          alu_req;
	alu_rsp_t          alu_rsp;
	logic [DATA_W-1:0] alu_result;
	alu_op_t           alu_op;

	logic              out_free, finish;
	logic [PTR_W-1:0]  new_sp;
	logic [DATA_W-1:0] new_top, new_pop;
	logic              new_err, is_arith;
	logic [PTR_W+INDEX_W-1:0] sp_ext;

	assign sp_next  = (sp_q == PTR_LAST) ? '0 : sp_q + 1'b1;
	assign sp_prev  = (sp_q == '0) ? PTR_LAST : sp_q - 1'b1;
	assign out_free = !out_valid_q || rsp.ready;
	assign finish   = (state_q == S_FINISH) && out_free;
	assign rd_word  = rdv_q ? ram_rdata : '0;
	assign is_arith = (action_q == ACT_ADD) || (action_q == ACT_SUB) ||
		(action_q == ACT_MUL) || (action_q == ACT_DIV) || (action_q == ACT_MOD);

	// action to unit operation
	always_comb begin
		case (action_q)
			ACT_SUB: alu_op = OP_SUB;
			ACT_MUL: alu_op = OP_MUL;
			ACT_DIV: alu_op = OP_DIV;
			ACT_MOD: alu_op = OP_MOD;
			default: alu_op = OP_ADD;
		endcase
	end

	sma_ram #(
		.WIDTH(DATA_W),
		.DEPTH(STACK_DEPTH)
	) u_stack_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	sma_alu_unit u_alu (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (alu_req),
		.opa   (below_q),
		.opb   (top_q),
		.rsp   (alu_rsp),
		.result(alu_result)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:     if (cmd.valid) state_d = S_RD_TOP;
			S_RD_TOP:   state_d = S_RD_BELOW;
			S_RD_BELOW: state_d = S_CAP;
			S_CAP:      state_d = is_arith ? S_START : S_FINISH;
			S_START:    state_d = S_EXEC;
			S_EXEC:     if (alu_rsp.done) state_d = S_FINISH;
			S_FINISH:   if (out_free) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		cmd.ready     = 1'b0;
		ram_re        = 1'b0;
		ram_raddr     = sp_q;
		alu_req.start = 1'b0;
		alu_req.op    = alu_op;
		case (state_q)
			S_IDLE:     cmd.ready = 1'b1;
			S_RD_TOP:   ram_re = 1'b1;
			S_RD_BELOW: begin
				ram_re    = 1'b1;
				ram_raddr = sp_prev;
			end
			S_START:    alu_req.start = 1'b1;
			default: begin
				ram_re = 1'b0;
			end
		endcase
	end

	// result of the operation
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = sp_q;
		ram_wdata = top_q;
		new_sp    = sp_q;
		new_top   = top_q;
		new_pop   = '0;
		new_err   = 1'b0;
		case (action_q)
			ACT_PUSH: begin
				ram_we    = 1'b1;
				ram_waddr = sp_next;
				ram_wdata = literal_q;
				new_sp    = sp_next;
			end
			ACT_DUP: begin
				ram_we    = 1'b1;
				ram_waddr = sp_next;
				ram_wdata = top_q;
				new_sp    = sp_next;
			end
			ACT_OVER: begin
				ram_we    = 1'b1;
				ram_waddr = sp_next;
				ram_wdata = below_q;
				new_sp    = sp_next;
			end
			ACT_DROP: begin
				new_sp  = sp_prev;
				new_pop = top_q;
			end
			ACT_INVERT: begin
				ram_we    = 1'b1;
				ram_wdata = ~top_q;
			end
			ACT_AND, ACT_OR, ACT_XOR, ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_MOD: begin
				ram_we    = 1'b1;
				ram_waddr = sp_prev;
				new_sp    = sp_prev;
				new_pop   = top_q;
				case (action_q)
					ACT_AND: ram_wdata = below_q & top_q;
					ACT_OR:  ram_wdata = below_q | top_q;
					ACT_XOR: ram_wdata = below_q ^ top_q;
					default: begin
						ram_wdata = alu_result;
						new_err   = alu_rsp.div_err;
					end
				endcase
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
		if (ram_we) begin
			new_top = ram_wdata;
		end else if (action_q == ACT_DROP) begin
			new_top = below_q;
		end
		ram_we = ram_we && finish;
	end

	assign sp_ext = {{INDEX_W{1'b0}}, new_sp};

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sp_q        <= '0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (finish) begin
				sp_q        <= new_sp;
				out_valid_q <= 1'b1;
				if (ram_we) begin
					valid_q[ram_waddr] <= 1'b1;
				end
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			action_q  <= cmd.action;
			literal_q <= cmd.literal;
		end
		if (ram_re) begin
			rdv_q <= valid_q[ram_raddr];
		end
		if (state_q == S_RD_BELOW) begin
			top_q <= rd_word;
		end
		if (state_q == S_CAP) begin
			below_q <= rd_word;
		end
		if (finish) begin
			out_top_q <= new_top;
			out_pop_q <= new_pop;
			out_err_q <= new_err;
			out_idx_q <= sp_ext[INDEX_W-1:0];
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.top_value    = out_top_q;
	assign rsp.popped_value = out_pop_q;
	assign rsp.divide_error = out_err_q;
	assign rsp.stack_index  = out_idx_q;
endmodule

### sv/sma_ram.sv
`timescale 1ns / 1ps

module sma_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

### sv/sma_alu_unit.sv
`timescale 1ns / 1ps

module sma_alu_unit (
	input  logic                    clk,
	input  logic                    arst_n,
	input  sma_pkg::alu_req_t       req,
	input  logic [sma_pkg::DATA_W-1:0] opa,
	input  logic [sma_pkg::DATA_W-1:0] opb,
	output sma_pkg::alu_rsp_t       rsp,
	output logic [sma_pkg::DATA_W-1:0] result
);
	import sma_pkg::*;

	localparam int SUM_W = DATA_W + 2;

	alu_state_t        state_q, state_d;
	alu_op_t           op_q;
	logic [DATA_W-1:0] x_q, y_q, z_q, res_q;
	logic [ITER_W-1:0] cnt_q;
	logic              nneg_q, dneg_q, err_q;

	logic [SUM_W-1:0]  add_x, add_y, sum;
	logic              add_sub;
	logic              is_div;
	logic              last_iter;
	logic              zero_div;

	assign is_div    = (op_q == OP_DIV) || (op_q == OP_MOD);
	assign last_iter = (cnt_q == '0);
	assign zero_div  = ((req.op == OP_DIV) || (req.op == OP_MOD)) && (opb == '0);

	// shared adder operand selection
	always_comb begin
		add_x   = '0;
		add_y   = '0;
		add_sub = 1'b0;
		case (state_q)
			U_ARITH: begin
				add_x   = {2'b00, x_q};
				add_y   = {2'b00, y_q};
				add_sub = (op_q == OP_SUB);
			end
			U_ABS_N: begin
				add_y   = {2'b00, z_q};
				add_sub = nneg_q;
			end
			U_ABS_D: begin
				add_y   = {2'b00, y_q};
				add_sub = dneg_q;
			end
			U_LOOP: begin
				if (is_div) begin
					// trial subtract of divisor from shifted remainder
					add_x   = {1'b0, x_q, z_q[DATA_W-1]};
					add_y   = {2'b00, y_q};
					add_sub = 1'b1;
				end else begin
					// shift-add multiply, multiplier scanned MSB first
					add_x = {2'b00, x_q[DATA_W-2:0], 1'b0};
					add_y = z_q[DATA_W-1] ? {2'b00, y_q} : '0;
				end
			end
			U_FIX: begin
				if (op_q == OP_DIV) begin
					add_y   = {2'b00, z_q};
					add_sub = nneg_q ^ dneg_q;
				end else begin
					add_y   = {2'b00, x_q};
					add_sub = nneg_q;
				end
			end
			default: begin
				add_sub = 1'b0;
			end
		endcase
	end

	assign sum = add_x + (add_sub ? ~add_y : add_y) + SUM_W'(add_sub);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			U_IDLE: begin
				if (req.start) begin
					case (req.op)
						OP_ADD, OP_SUB: state_d = U_ARITH;
						OP_MUL:         state_d = U_LOOP;
						default:        state_d = (opb == '0) ? U_DONE : U_ABS_N;
					endcase
				end
			end
			U_ARITH: state_d = U_DONE;
			U_ABS_N: state_d = U_ABS_D;
			U_ABS_D: state_d = U_LOOP;
			U_LOOP: begin
				if (last_iter) begin
					state_d = is_div ? U_FIX : U_DONE;
				end
			end
			U_FIX:   state_d = U_DONE;
			U_DONE:  state_d = U_IDLE;
			default: state_d = U_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			U_IDLE: begin
				if (req.start) begin
					op_q   <= req.op;
					err_q  <= zero_div;
					nneg_q <= opa[DATA_W-1];
					dneg_q <= opb[DATA_W-1];
					cnt_q  <= ITER_LAST;
					if (req.op == OP_MUL) begin
						x_q <= '0;
						y_q <= opa;
						z_q <= opb;
					end else begin
						x_q <= opa;
						y_q <= opb;
						z_q <= opa;
					end
					// zero divisor: result is zero and flagged
					if (zero_div) begin
						res_q <= '0;
					end
				end
			end
			U_ARITH: res_q <= sum[DATA_W-1:0];
			U_ABS_N: z_q <= sum[DATA_W-1:0];
			U_ABS_D: begin
				y_q   <= sum[DATA_W-1:0];
				x_q   <= '0;
				cnt_q <= ITER_LAST;
			end
			U_LOOP: begin
				cnt_q <= cnt_q - 1'b1;
				if (is_div) begin
					if (!sum[SUM_W-1]) begin
						x_q <= sum[DATA_W-1:0];
					end else begin
						x_q <= add_x[DATA_W-1:0];
					end
					z_q <= {z_q[DATA_W-2:0], ~sum[SUM_W-1]};
				end else begin
					x_q <= sum[DATA_W-1:0];
					z_q <= {z_q[DATA_W-2:0], 1'b0};
					if (last_iter) begin
						res_q <= sum[DATA_W-1:0];
					end
				end
			end
			U_FIX: res_q <= sum[DATA_W-1:0];
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	assign rsp.done    = (state_q == U_DONE);
	assign rsp.div_err = err_q;
	assign result      = res_q;
endmodule

### sv/sma_checker.sv
`timescale 1ns / 1ps

module sma_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         cmd_valid,
	input logic                         cmd_ready,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic [sma_pkg::DATA_W-1:0]   rsp_top_value,
	input logic                         rsp_divide_error,
	input logic [sma_pkg::INDEX_W-1:0]  rsp_stack_index
);
	import sma_pkg::*;

	// a result held by the receiver stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its top value and stack index
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_top_value) && $stable(rsp_stack_index))
		else $error("result payload changed while stalled");

	// one item in work at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("second item accepted while busy");

	// a zero divisor always leaves zero on top
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_divide_error |-> rsp_top_value == '0)
		else $error("divide error with nonzero top");
endmodule

bind stack_machine_alu sma_checker u_sma_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.cmd_valid       (cmd.valid),
	.cmd_ready       (cmd.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_top_value   (rsp.top_value),
	.rsp_divide_error(rsp.divide_error),
	.rsp_stack_index (rsp.stack_index)
);
